// ===== sv/affine_transform_stack_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the affine transform stack
// Shared property wrappers used by the top level checks.
// ----------------------------------------------------------------------------
`ifndef AFFINE_TRANSFORM_STACK_MACROS_SVH
`define AFFINE_TRANSFORM_STACK_MACROS_SVH

// assert that a implies b on the same edge
`define ATS_ASSERT_IMPL(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("check failed");

// assert that a implies b on the next edge
`define ATS_ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("check failed");

`endif

// ===== sv/ats_pkg.sv =====
// ----------------------------------------------------------------------------
// ats_pkg
// Types, opcodes and fixed-point helpers for the affine transform stack.
// ----------------------------------------------------------------------------
package ats_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    typedef enum logic [1:0] {
        OP_ENTER     = 2'd0,
        OP_SET       = 2'd1,
        OP_EXIT      = 2'd2,
        OP_TRANSFORM = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_SAT   = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
        logic signed [31:0] coef_d;
        logic signed [31:0] coef_e;
        logic signed [31:0] coef_f;
        logic signed [31:0] point_in_x;
        logic signed [31:0] point_in_y;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] point_out_x;
        logic signed [31:0] point_out_y;
    } out_item_t;

    // saturate a wide signed sum to 32 bits
    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        logic [32:0] r;
        if (v > 66'sh0_7FFF_FFFF)
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -66'sh0_8000_0000)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

endpackage

// ===== sv/ats_mac.sv =====
// ----------------------------------------------------------------------------
// ats_mac
// Shared registered multiplier with floor shift by the fraction width.
// ----------------------------------------------------------------------------
module ats_mac
    import ats_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic signed [31:0] op_x,
    input  logic signed [31:0] op_y,
    output logic signed [63:0] prod_reg
);
    logic signed [63:0] prod_next;

    // arithmetic right shift is floor division by 2^FRAC_BITS
    assign prod_next = (op_x * op_y) >>> FRAC_BITS;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end
endmodule

// ===== sv/ats_store.sv =====
// ----------------------------------------------------------------------------
// ats_store
// Matrix stack memory: one word per coefficient, one read and one write port.
// ----------------------------------------------------------------------------
module ats_store
    import ats_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int AW = $clog2(STACK_DEPTH * 6)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata_reg
);
    logic [31:0] mem [STACK_DEPTH*6];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end
endmodule

// ===== sv/affine_transform_stack.sv =====
// ----------------------------------------------------------------------------
// affine_transform_stack
// Flow: one item in flight; the next transfer is accepted once the result
//   has been handed to the output register. The datapath uses one shared
//   32x32 multiplier and one memory read port. A finished result waits in
//   the output register; the next item's result waits in S_OUT.
// Reset: synchronous active low; product = identity, level = 0, height = 0.
//   Stack memory is not cleared (entries are written before they are read).
// ----------------------------------------------------------------------------
`include "affine_transform_stack_macros.svh"

module affine_transform_stack
    import ats_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_we,
    input  logic [30:0] cfg_data
);
    localparam int AW = $clog2(STACK_DEPTH * 6);
    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam logic [31:0] QONE = 32'(1) << FRAC_BITS;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_WR    = 7'b0000010,   // write six words of a matrix
        S_MUL   = 7'b0000100,   // product term sequence
        S_LOAD  = 7'b0001000,   // read top or a level into m_reg
        S_CHK   = 7'b0010000,   // identity test after pop
        S_DONE  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // running product, level, config
    logic [31:0] p_reg [6];
    logic [31:0] p_next [6];
    logic [31:0] m_reg [6];    // operand matrix (set coefs or loaded level)
    logic [31:0] m_next [6];
    logic [31:0] acc_reg [6];  // product being built
    logic [31:0] acc_next [6];
    logic [LW-1:0] level_reg, level_next;
    logic [30:0] vh_reg;
    in_item_t    item_reg, item_next;
    out_item_t   res_reg, res_next;           // result being built
    out_item_t   out_reg, out_next;           // result offered on m_
    logic        ovalid_reg, ovalid_next;
    logic        sat_reg, sat_next;
    logic        rebuild_reg, rebuild_next;   // exit rebuild in progress
    logic [LW-1:0] lvl_reg, lvl_next;         // rebuild level walker
    logic [3:0]  cnt_reg, cnt_next;
    logic signed [65:0] sum_reg, sum_next;

    // memory
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata, mem_rdata;

    ats_store #(.STACK_DEPTH(STACK_DEPTH), .AW(AW)) u_store (
        .aclk     (aclk),
        .we       (mem_we),
        .waddr    (mem_waddr),
        .wdata    (mem_wdata),
        .raddr    (mem_raddr),
        .rdata_reg(mem_rdata)
    );

    // shared multiplier: term cnt (0..11) selects operands
    logic signed [31:0] mx, my;
    logic signed [63:0] mprod;

    ats_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .aclk    (aclk),
        .op_x    (mx),
        .op_y    (my),
        .prod_reg(mprod)
    );

    logic is_xf;
    assign is_xf = (item_reg.opcode == OP_TRANSFORM);

    // compose r = P*M: for out word j: terms P[row]*M[col]
    // out j: row sel = j odd -> (1,3) else (0,2); M index = 2*(j/2) + {0,1}
    // transform: x term uses (0,x),(2,y), y term (1,x),(3,y)
    // left operand is always P; a rebuild restarts P at identity and folds
    // in one level at a time
    logic [3:0] tcnt;     // term number being issued
    logic [2:0] oj;
    logic       tk;
    always_comb begin
        tcnt = cnt_reg;
        oj   = tcnt[3:1];
        tk   = tcnt[0];
        mx   = $signed(p_reg[{1'b0, tk, oj[0]}]);
        if (is_xf) begin
            my = tk ? item_reg.point_in_y : item_reg.point_in_x;
        end else begin
            my = $signed(m_reg[{oj[2:1], 1'b0} + {2'b00, tk}]);
        end
    end

    logic [AW-1:0] top_base;
    logic [AW-1:0] lvl_base;
    assign top_base = AW'((level_reg - LW'(1)) * 6);
    assign lvl_base = AW'(lvl_reg * 6);

    logic [32:0] satv;
    logic [32:0] flipv;
    logic signed [31:0] last_word;

    always_comb begin
        state_next   = state_reg;
        p_next       = p_reg;
        m_next       = m_reg;
        acc_next     = acc_reg;
        level_next   = level_reg;
        item_next    = item_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        ovalid_next  = ovalid_reg;
        sat_next     = sat_reg;
        rebuild_next = rebuild_reg;
        lvl_next     = lvl_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        mem_we       = 1'b0;
        mem_waddr    = top_base + AW'(cnt_reg[2:0]);
        mem_wdata    = m_reg[cnt_reg[2:0]];
        mem_raddr    = top_base + AW'(cnt_reg[2:0]);
        satv         = sat32(sum_reg);
        flipv        = '0;
        last_word    = '0;
        s_ready      = (state_reg == S_IDLE);

        if (ovalid_reg && m_ready) ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    item_next = s_data;
                    sat_next  = 1'b0;
                    cnt_next  = '0;
                    sum_next  = '0;
                    rebuild_next = 1'b0;
                    res_next  = '{status: ST_OK, point_out_x: '0, point_out_y: '0};
                    m_next[0] = s_data.coef_a;
                    m_next[1] = s_data.coef_b;
                    m_next[2] = s_data.coef_c;
                    m_next[3] = s_data.coef_d;
                    m_next[4] = s_data.coef_e;
                    m_next[5] = s_data.coef_f;
                    case (s_data.opcode)
                        OP_ENTER: begin
                            if (level_reg >= LW'(STACK_DEPTH)) begin
                                res_next.status = ST_FULL;
                                state_next = S_OUT;
                            end else begin
                                m_next = '{QONE, 32'd0, 32'd0, QONE, 32'd0, 32'd0};
                                level_next = level_reg + LW'(1);
                                state_next = S_WR;
                            end
                        end
                        OP_SET: begin
                            if (level_reg == '0) level_next = LW'(1);
                            state_next = S_WR;
                        end
                        OP_EXIT: begin
                            if (level_reg == '0) begin
                                res_next.status = ST_EMPTY;
                                state_next = S_OUT;
                            end else begin
                                state_next = S_LOAD;
                            end
                        end
                        default: begin
                            state_next = S_MUL;
                        end
                    endcase
                end
            end
            S_WR: begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd5) begin
                    cnt_next   = '0;
                    state_next = (item_reg.opcode == OP_SET) ? S_MUL : S_OUT;
                end
            end
            S_LOAD: begin
                // read 6 words; registered data arrives in the next cycle (cnt 1..6)
                mem_raddr = (rebuild_reg ? lvl_base : top_base) + AW'(cnt_reg[2:0]);
                if (cnt_reg != 4'd0) m_next[cnt_reg[2:0] - 3'd1] = mem_rdata;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd6) begin
                    cnt_next   = '0;
                    state_next = rebuild_reg ? S_MUL : S_CHK;
                end
            end
            S_CHK: begin
                level_next = level_reg - LW'(1);
                if (m_reg[0] == QONE && m_reg[1] == '0 && m_reg[2] == '0 &&
                    m_reg[3] == QONE && m_reg[4] == '0 && m_reg[5] == '0) begin
                    state_next = S_OUT;
                end else begin
                    p_next       = '{QONE, 32'd0, 32'd0, QONE, 32'd0, 32'd0};
                    acc_next     = '{QONE, 32'd0, 32'd0, QONE, 32'd0, 32'd0};
                    rebuild_next = 1'b1;
                    lvl_next     = '0;
                    state_next   = (level_reg == LW'(1)) ? S_DONE : S_LOAD;
                end
            end
            S_MUL: begin
                // issue terms cnt 0..11 (transform 0..3); accumulate the registered product in the next cycle
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg != 4'd0) begin
                    sum_next = sum_reg + 66'(mprod);
                    if (!cnt_reg[0]) begin
                        // pair done for word (cnt-1)/2
                        if (is_xf) begin
                            last_word = $signed(p_reg[{2'b10, cnt_reg[2]}]);
                        end else begin
                            if (cnt_reg[3:1] == 3'd5)
                                last_word = $signed(p_reg[4]);
                            if (cnt_reg[3:1] == 3'd6)
                                last_word = $signed(p_reg[5]);
                        end
                        satv = sat32(sum_reg + 66'(mprod) + 66'(last_word));
                        sum_next = '0;
                        if (satv[32]) sat_next = 1'b1;
                        if (is_xf) begin
                            if (cnt_reg == 4'd2) begin
                                res_next.point_out_x = satv[31:0];
                            end else begin
                                flipv = sat32(66'($signed({1'b0, vh_reg})) -
                                              66'($signed(satv[31:0])));
                                res_next.point_out_y = flipv[31:0];
                                if (flipv[32] || satv[32] || sat_reg)
                                    res_next.status = ST_SAT;
                                state_next = S_OUT;
                            end
                        end else begin
                            m_next[cnt_reg[3:1] - 3'd1] = m_reg[cnt_reg[3:1] - 3'd1];
                            acc_next[cnt_reg[3:1] - 3'd1] = satv[31:0];
                            if (cnt_reg == 4'd12) begin
                                cnt_next = '0;
                                state_next = S_DONE;
                            end
                        end
                    end
                end
            end
            S_DONE: begin
                p_next = acc_reg;
                if (rebuild_reg && (lvl_reg + LW'(1)) < level_reg) begin
                    lvl_next   = lvl_reg + LW'(1);
                    state_next = S_LOAD;
                end else begin
                    if (sat_reg) res_next.status = ST_SAT;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // hand over once the output register is free or being drained
                if (!ovalid_reg || m_ready) begin
                    out_next    = res_reg;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            p_reg       <= '{QONE, 32'd0, 32'd0, QONE, 32'd0, 32'd0};
            level_reg   <= '0;
            vh_reg      <= '0;
            ovalid_reg  <= 1'b0;
            rebuild_reg <= 1'b0;
            sat_reg     <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            p_reg       <= p_next;
            level_reg   <= level_next;
            ovalid_reg  <= ovalid_next;
            rebuild_reg <= rebuild_next;
            sat_reg     <= sat_next;
            cnt_reg     <= cnt_next;
            if (cfg_we) vh_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        m_reg    <= m_next;
        acc_reg  <= acc_next;
        item_reg <= item_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        lvl_reg  <= lvl_next;
        sum_reg  <= sum_next;
    end

    assign m_valid = ovalid_reg;
    assign m_data  = out_reg;

    `ATS_ASSERT_IMPL(a_level_bound, aclk, aresetn, 1'b1, level_reg <= LW'(STACK_DEPTH))
    `ATS_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, state_reg != S_IDLE, !s_ready)
    `ATS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
endmodule

// ===== test/tb_affine_transform_stack.sv =====
// ----------------------------------------------------------------------------
// tb_affine_transform_stack
// Self-checking bench: directed stack/saturation cases, then random
// well-formed push/set/transform/pop traffic, with random gaps on both sides
// and a phase of long receiver hold-offs. A local Q16.16 model predicts each result.
// ----------------------------------------------------------------------------
module tb_affine_transform_stack;
    import ats_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = STACK_DEPTH_DEF;
    localparam int FRAC  = FRAC_BITS_DEF;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC;

    typedef logic signed [31:0] mat_t [6];

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_we = 1'b0;
    logic [30:0] cfg_data = '0;

    affine_transform_stack DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // predictor state
    mat_t        stack_mats [DEPTH];
    mat_t        product;
    int          level;
    logic [30:0] height;

    out_item_t   expected_q [$];
    int          errors = 0;
    bit          hold_off = 1'b0;   // long receiver stall request

    // ---------------- fixed-point helpers ----------------
    function automatic logic signed [63:0] qmul(logic signed [31:0] x, logic signed [31:0] y);
        logic signed [63:0] p;
        p = 64'(x) * 64'(y);
        return p >>> FRAC;          // arithmetic shift == floor
    endfunction

    function automatic logic signed [31:0] clip(logic signed [65:0] v, ref bit sat);
        if (v > 66'sh7FFF_FFFF) begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -66'sh8000_0000) begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic void ident(output mat_t m);
        m = '{ONE, 0, 0, ONE, 0, 0};
    endfunction

    // r = p * q (q applied first)
    function automatic void compose(input mat_t p, input mat_t q, output mat_t r, ref bit sat);
        r[0] = clip(66'(qmul(p[0], q[0])) + 66'(qmul(p[2], q[1])), sat);
        r[1] = clip(66'(qmul(p[1], q[0])) + 66'(qmul(p[3], q[1])), sat);
        r[2] = clip(66'(qmul(p[0], q[2])) + 66'(qmul(p[2], q[3])), sat);
        r[3] = clip(66'(qmul(p[1], q[2])) + 66'(qmul(p[3], q[3])), sat);
        r[4] = clip(66'(qmul(p[0], q[4])) + 66'(qmul(p[2], q[5])) + 66'(p[4]), sat);
        r[5] = clip(66'(qmul(p[1], q[4])) + 66'(qmul(p[3], q[5])) + 66'(p[5]), sat);
    endfunction

    // advance the stack model by one item, return its result
    function automatic out_item_t predict_stack_op(in_item_t it);
        out_item_t r;
        bit sat;
        mat_t m, id, acc, t;
        bit is_id;
        r = '0;
        sat = 1'b0;
        ident(id);
        case (opcode_t'(it.opcode))
            OP_ENTER: begin
                if (level >= DEPTH) r.status = ST_FULL;
                else begin
                    stack_mats[level] = id;
                    level++;
                end
            end
            OP_SET: begin
                m = '{it.coef_a, it.coef_b, it.coef_c, it.coef_d, it.coef_e, it.coef_f};
                if (level == 0) level = 1;
                stack_mats[level-1] = m;
                compose(product, m, t, sat);
                product = t;
                if (sat) r.status = ST_SAT;
            end
            OP_EXIT: begin
                if (level == 0) r.status = ST_EMPTY;
                else begin
                    is_id = (stack_mats[level-1] == id);
                    level--;
                    if (!is_id) begin
                        acc = id;
                        for (int l = 0; l < level; l++) begin
                            compose(acc, stack_mats[l], t, sat);
                            acc = t;
                        end
                        product = acc;
                        if (sat) r.status = ST_SAT;
                    end
                end
            end
            default: begin
                r.point_out_x = clip(66'(qmul(product[0], it.point_in_x))
                    + 66'(qmul(product[2], it.point_in_y)) + 66'(product[4]), sat);
                t[0] = clip(66'(qmul(product[1], it.point_in_x))
                    + 66'(qmul(product[3], it.point_in_y)) + 66'(product[5]), sat);
                r.point_out_y = clip(66'({1'b0, height}) - 66'(t[0]), sat);
                if (sat) r.status = ST_SAT;
            end
        endcase
        return r;
    endfunction

    // ---------------- sender ----------------
    // valid drops only when a gap follows
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_item(in_item_t it);
        idle_gap();
        s_valid <= 1'b1;
        s_data  <= it;
        expected_q.insert(expected_q.size(), predict_stack_op(it));
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (expected_q.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (300) @(posedge aclk);   // quiet tail; a stray result shows up here
    endtask

    task automatic write_height(logic [30:0] h);
        @(posedge aclk);
        cfg_we   <= 1'b1;
        cfg_data <= h;
        height = h;
        @(posedge aclk);
        cfg_we   <= 1'b0;
    endtask

    function automatic in_item_t make_item(opcode_t op);
        in_item_t it;
        it = '0;
        it.opcode = op;
        if (op == OP_SET) begin
            it.coef_a = $urandom; it.coef_b = $urandom; it.coef_c = $urandom;
            it.coef_d = $urandom; it.coef_e = $urandom; it.coef_f = $urandom;
        end else if (op == OP_TRANSFORM) begin
            it.point_in_x = $urandom;
            it.point_in_y = $urandom;
        end
        return it;
    endfunction

    // moderate matrix: small scale/rotation-like terms, random translation
    function automatic logic signed [31:0] coef_near(logic signed [31:0] base);
        return base + $signed(32'($urandom_range(0, 65535)) - 32'sd32768);
    endfunction

    function automatic in_item_t tame_set();
        in_item_t it;
        it = make_item(OP_SET);
        it.coef_a = coef_near(ONE);
        it.coef_b = coef_near(0);
        it.coef_c = coef_near(0);
        it.coef_d = coef_near(ONE);
        it.coef_e = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        it.coef_f = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        return it;
    endfunction

    // ---------------- test tasks ----------------
    task automatic test_directed();
        in_item_t it;
        send_item(make_item(OP_EXIT));                 // pop on empty stack
        it = '0; it.opcode = OP_TRANSFORM;
        it.point_in_x = 32'sh7FFF_FFFF; it.point_in_y = 32'sh8000_0000;
        send_item(it);                                 // identity with extremes
        it = tame_set();
        send_item(it);                                 // set on empty stack pushes
        send_item(make_item(OP_ENTER));
        it = '0; it.opcode = OP_SET;                   // saturating set, extreme coefs
        it.coef_a = 32'sh8000_0000; it.coef_b = 32'sh7FFF_FFFF;
        it.coef_c = 32'sh8000_0000; it.coef_d = 32'sh7FFF_FFFF;
        it.coef_e = 32'sh7FFF_FFFF; it.coef_f = 32'sh8000_0000;
        send_item(it);
        it = make_item(OP_TRANSFORM);
        it.point_in_x = 32'sh8000_0000; it.point_in_y = 32'sh7FFF_FFFF;
        send_item(it);
        send_item(make_item(OP_EXIT));                 // non-identity pop: rebuild
        send_item(make_item(OP_ENTER));
        send_item(make_item(OP_EXIT));                 // identity pop: no rebuild
        for (int i = 0; i < DEPTH; i++) send_item(make_item(OP_ENTER));  // last one full
        send_item(make_item(OP_TRANSFORM));
    endtask

    task automatic test_random_traffic(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 15)      send_item(make_item(OP_ENTER));
            else if (r < 35) send_item(($urandom_range(0, 9) == 0) ? make_item(OP_SET)
                                                                   : tame_set());
            else if (r < 50) send_item(make_item(OP_EXIT));
            else             send_item(make_item(OP_TRANSFORM));
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        test_random_traffic(12);
        hold_off = 1'b0;
    endtask

    // empty the stack so the next phase starts from a known depth
    task automatic test_unwind();
        while (level > 0) send_item(make_item(OP_EXIT));
        send_item(make_item(OP_EXIT));
    endtask

    // ---------------- receiver ----------------
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                // long stall, then a single ready cycle
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                stall = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
                m_ready <= 1'b0;
                repeat (stall - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // result checker: compare every transfer with the oldest expectation
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%t: unexpected result %h", $realtime, m_data);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (m_data.status !== want.status) begin
                    $display("%t: status exp %0d got %0d", $realtime,
                             want.status, m_data.status);
                    errors++;
                end
                if (m_data.point_out_x !== want.point_out_x) begin
                    $display("%t: x exp %h got %h", $realtime,
                             want.point_out_x, m_data.point_out_x);
                    errors++;
                end
                if (m_data.point_out_y !== want.point_out_y) begin
                    $display("%t: y exp %h got %h", $realtime,
                             want.point_out_y, m_data.point_out_y);
                    errors++;
                end
            end
        end
    end

    // ---------------- sequence ----------------
    initial begin
        level  = 0;
        height = '0;
        ident(product);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        wait_drained();
        write_height(31'h7FFF_FFFF);
        test_unwind();
        test_random_traffic(600);
        test_backpressure();
        wait_drained();
        write_height(31'h0);
        test_random_traffic(600);
        wait_drained();
        write_height(31'($urandom));
        test_random_traffic(600);
        wait_drained();

        if (expected_q.size() != 0) errors++;
        if (errors == 0) $display("affine_transform_stack test passed");
        else $display("affine_transform_stack test failed");
        $finish;
    end

    // watchdog
    initial begin
        #50ms;
        $display("affine_transform_stack test failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/ats_pkg.sv
sv/ats_mac.sv
sv/ats_store.sv
sv/affine_transform_stack.sv
test/tb_affine_transform_stack.sv
